FILE: design/lzd_pkg.sv
`timescale 1ns / 1ps

package lzd_pkg;

    localparam int LIT_W   = 8;
    localparam int LEN_W   = 7;
    localparam int DIST_W  = 13;
    localparam int ERR_W   = 2;
    localparam int FRAME_W = 32;

    // error codes carried on the result channel
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIST     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [ERR_W-1:0] ERR_SIZE     = 2'd3;

    // register index taken from the word address
    localparam logic REG_FRAME_SIZE = 1'b0;

    typedef struct packed {
        logic              is_match;
        logic [LIT_W-1:0]  lit;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
        logic              fin;
    } token_t;

    typedef struct packed {
        logic             valid;
        logic             use_ram;
        logic             last;
        logic [ERR_W-1:0] err;
        logic [LIT_W-1:0] lit;
    } out_ctl_t;

endpackage

FILE: design/lzd_ram.sv
`timescale 1ns / 1ps

module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/lzd_check.sv
`timescale 1ns / 1ps

module lzd_check #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  lzd_pkg::token_t                   tok,
    input  logic [lzd_pkg::FRAME_W-1:0]       bytes_produced,
    input  logic [lzd_pkg::FRAME_W-1:0]       frame_size,
    output logic [lzd_pkg::ERR_W-1:0]         err
);

    import lzd_pkg::*;

    logic [LEN_W-1:0]   count;
    logic [FRAME_W:0]   total;
    logic [FRAME_W-1:0] dist_ext;
    logic               bad_dist;

    assign count    = tok.is_match ? tok.len : LEN_W'(1);
    assign total    = {1'b0, bytes_produced} + (FRAME_W+1)'(count);
    assign dist_ext = FRAME_W'(tok.distance);
    assign bad_dist = tok.is_match && ((tok.distance == '0)
                    || (dist_ext > FRAME_W'(WINDOW_DEPTH))
                    || (dist_ext > bytes_produced));

    // distance first, then overflow, then end-of-frame size
    always_comb
    begin
        if (bad_dist)
        begin
            err = ERR_DIST;
        end
        else if (total > {1'b0, frame_size})
        begin
            err = ERR_OVERFLOW;
        end
        else if (tok.fin && (total != {1'b0, frame_size}))
        begin
            err = ERR_SIZE;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

endmodule

FILE: design/lzd_seq.sv
`timescale 1ns / 1ps

module lzd_seq #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int MAX_MATCH    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lzd_pkg::token_t                   in_tok,
    input  logic                              out_ready,
    output lzd_pkg::out_ctl_t                 out_ctl,
    input  logic [lzd_pkg::FRAME_W-1:0]       frame_size,
    output logic                              ram_we,
    output logic [$clog2(WINDOW_DEPTH)-1:0]   ram_waddr,
    output logic                              ram_re,
    output logic [$clog2(WINDOW_DEPTH)-1:0]   ram_raddr
);

    import lzd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int SW = ((AW > DIST_W) ? AW : DIST_W) + 2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    token_t             tok_reg, tok_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [AW-1:0]      wptr_reg, wptr_next;
    logic [AW-1:0]      rptr_reg, rptr_next;
    logic [FRAME_W-1:0] bp_reg, bp_next;

    logic [ERR_W-1:0]   chk_err;
    logic [SW-1:0]      src_sum;
    logic [AW-1:0]      src_addr;
    logic [AW-1:0]      wptr_inc;
    logic [AW-1:0]      rptr_inc;
    logic               out_fire;

    lzd_check #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_check (
        .tok            (tok_reg),
        .bytes_produced (bp_reg),
        .frame_size     (frame_size),
        .err            (chk_err)
    );

    // copy source: write pointer minus distance, modulo the window
    assign src_sum  = SW'(wptr_reg) + SW'(WINDOW_DEPTH) - SW'(tok_reg.distance);
    assign src_addr = (src_sum >= SW'(WINDOW_DEPTH)) ? AW'(src_sum - SW'(WINDOW_DEPTH))
                                                     : AW'(src_sum);
    assign wptr_inc = (wptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc = (rptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_ctl.valid   = (state_reg == S_EMIT);
    assign out_ctl.use_ram = tok_reg.is_match && (err_reg == ERR_NONE);
    assign out_ctl.last    = (err_reg != ERR_NONE) || !tok_reg.is_match
                          || (remain_reg == LEN_W'(1));
    assign out_ctl.err     = err_reg;
    assign out_ctl.lit     = (err_reg != ERR_NONE) ? '0 : tok_reg.lit;
    assign out_fire        = out_ctl.valid && out_ready;

    assign ram_waddr = wptr_reg;

    always_comb
    begin
        state_next  = state_reg;
        tok_next    = tok_reg;
        err_next    = err_reg;
        remain_next = remain_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        bp_next     = bp_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = src_addr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tok_next = in_tok;
                    if (in_tok.len > LEN_W'(MAX_MATCH))
                    begin
                        tok_next.len = LEN_W'(MAX_MATCH);
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                err_next    = chk_err;
                remain_next = tok_reg.is_match ? tok_reg.len : LEN_W'(1);
                if ((chk_err != ERR_NONE) || !tok_reg.is_match)
                begin
                    state_next = S_EMIT;
                end
                else if (tok_reg.len == '0)
                begin
                    if (tok_reg.fin)
                    begin
                        bp_next   = '0;
                        wptr_next = '0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    rptr_next  = src_addr;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                ram_raddr = rptr_inc;
                if (out_fire)
                begin
                    if (err_reg != ERR_NONE)
                    begin
                        if (tok_reg.fin)
                        begin
                            bp_next   = '0;
                            wptr_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wptr_next   = wptr_inc;
                        bp_next     = bp_reg + 1'b1;
                        remain_next = remain_reg - 1'b1;
                        if (remain_reg == LEN_W'(1))
                        begin
                            if (tok_reg.fin)
                            begin
                                bp_next   = '0;
                                wptr_next = '0;
                            end
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            rptr_next = rptr_inc;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            err_reg    <= ERR_NONE;
            remain_reg <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            bp_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            err_reg    <= err_next;
            remain_reg <= remain_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            bp_reg     <= bp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

endmodule

FILE: design/lzss_token_decoder.sv
`timescale 1ns / 1ps

// lzss_token_decoder: turns parsed lzss tokens into the decoded byte stream
//
// input stream (s_axis): one token per transfer; tuser says literal or match,
// tlast marks the final token of a frame. output stream (m_axis): one decoded
// byte per transfer; tlast marks a token's last result, tuser an error code.
// an erroring token gives a single result, byte 0, not its bytes. frame_size
// must be written over the apb port while the block is idle (not enforced).
//
// timing: a token is taken, checked in the next cycle, then its results go
// out one per cycle while the receiver is ready. a literal or an error gives
// a single result, a zero-length match none. the per-byte rate is set by the
// single history ram port pair: each copied byte is written back in the same
// cycle the next source byte is read.
//
// reset clears the frame byte count, the ring pointers and frame_size; the
// history ram is not cleared. when the receiver stalls, the current result
// holds and the block takes no new token until all results have gone out.

module lzss_token_decoder #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int MAX_MATCH    = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // token input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // literal_byte, match_length, match_distance, zero pad
    input  logic        s_axis_tuser,   // is_match
    input  logic        s_axis_tlast,   // final_token

    // decoded bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [1:0]  m_axis_tuser,   // error_code
    output logic        m_axis_tlast    // run_last
);

    import lzd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [FRAME_W-1:0] frame_size_reg;
    logic               cfg_wr;

    token_t             in_tok;
    out_ctl_t           out_ctl;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [LIT_W-1:0]   ram_rdata;

    // same-address forward for a copy distance of one
    logic               byp_reg;
    logic [LIT_W-1:0]   byp_data_reg;
    logic [LIT_W-1:0]   hist_byte;

    // apb register: frame_size at word 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAME_SIZE) ? frame_size_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_FRAME_SIZE))
        begin
            frame_size_reg <= pwdata;
        end
    end

    // unpack the token
    assign in_tok.is_match = s_axis_tuser;
    assign in_tok.lit      = s_axis_tdata[7:0];
    assign in_tok.len      = s_axis_tdata[14:8];
    assign in_tok.distance = s_axis_tdata[27:15];
    assign in_tok.fin      = s_axis_tlast;

    lzd_seq #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_MATCH    (MAX_MATCH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_tok     (in_tok),
        .out_ready  (m_axis_tready),
        .out_ctl    (out_ctl),
        .frame_size (frame_size_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    // history ring, written with every byte that goes out but error results
    lzd_ram #(
        .WIDTH (LIT_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_axis_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the ram returns old data when read and written at one address,
    // so keep the byte being written for that case
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (ram_re)
        begin
            byp_reg <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            byp_data_reg <= m_axis_tdata;
        end
    end

    assign hist_byte = byp_reg ? byp_data_reg : ram_rdata;

    // result channel
    assign m_axis_tvalid = out_ctl.valid;
    assign m_axis_tdata  = out_ctl.use_ram ? hist_byte : out_ctl.lit;
    assign m_axis_tuser  = out_ctl.err;
    assign m_axis_tlast  = out_ctl.last;

    // one token at a time: never taking a token while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("token taken while a result is pending");

    // an error result is a single zero byte that closes the token
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ERR_NONE)) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("malformed error result");

    // after the last result of a token the block is ready again
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after last result transfer");

    // the cycle after a token transfer is the check cycle: no result yet
    a_check_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("check cycle skipped");

endmodule
